### hw/rtl/assert_macros.svh
// Assertion macros used by the top RTL file of the pair trigger.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check that is switched off while reset is asserted.
`define PAT_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("pair trigger assertion failed");

// Concurrent check that must also hold during reset.
`define PAT_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("pair trigger assertion failed");

`endif

### hw/rtl/pat_pkg.sv
// Shared types and constants of the pair acoplanarity trigger.
package pat_pkg;

  localparam int ENERGY_W  = 16;
  localparam int ANGLE_W   = 12;
  localparam int PAIRS_W   = 11;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_W     = 16;

  // Angle steps of half a turn; the fold and acoplanarity are taken against it.
  localparam logic [ANGLE_W-1:0] HALF_TURN = ANGLE_W'(2048);
  localparam logic [PAIRS_W-1:0] PAIRS_MAX = '1;

  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
  typedef logic [CFG_W-1:0]     cfg_data_t;

  // Register indexes of the configuration port.
  localparam cfg_idx_t REG_LEAD_CUT   = 3'd0;
  localparam cfg_idx_t REG_SUB_CUT    = 3'd1;
  localparam cfg_idx_t REG_ACOP_MIN   = 3'd2;
  localparam cfg_idx_t REG_ACOP_MAX   = 3'd3;
  localparam cfg_idx_t REG_BAL_MIN    = 3'd4;
  localparam cfg_idx_t REG_BAL_MAX    = 3'd5;
  localparam cfg_idx_t REG_THRESHOLD  = 3'd6;

  typedef struct packed {
    logic [ENERGY_W-1:0] lead_energy_cut;
    logic [ENERGY_W-1:0] sub_energy_cut;
    logic [ANGLE_W-1:0]  acop_min;
    logic [ANGLE_W-1:0]  acop_max;
    logic [ENERGY_W-1:0] balance_min;
    logic [ENERGY_W-1:0] balance_max;
    logic [PAIRS_W-1:0]  pair_threshold;
  } pat_cfg_t;

endpackage

### hw/rtl/pat_in_if.sv
// Candidate input channel of the pair trigger.
interface pat_in_if;
  import pat_pkg::*;

  logic                valid;
  logic                ready;
  logic [ENERGY_W-1:0] energy;
  logic [ANGLE_W-1:0]  angle;
  logic                candidate_valid;
  logic                last;

  modport source(output valid, energy, angle, candidate_valid, last, input ready);
  modport sink(input valid, energy, angle, candidate_valid, last, output ready);
endinterface

### hw/rtl/pat_out_if.sv
// Event result channel of the pair trigger.
interface pat_out_if;
  import pat_pkg::*;

  logic               valid;
  logic               ready;
  logic [PAIRS_W-1:0] pair_count;
  logic               accept;
  logic               overflow;

  modport source(output valid, pair_count, accept, overflow, input ready);
  modport sink(input valid, pair_count, accept, overflow, output ready);
endinterface

### hw/rtl/pat_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
module pat_ram #(
  parameter int WIDTH = 28,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem_r[raddr];
    end
  end

endmodule

### hw/rtl/pat_pair_check.sv
// Two-stage pipelined cut test of one candidate pair.
module pat_pair_check (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_vld,
  input  logic [pat_pkg::ENERGY_W-1:0] cand_energy,
  input  logic [pat_pkg::ANGLE_W-1:0]  cand_angle,
  input  logic [pat_pkg::ENERGY_W-1:0] ref_energy,
  input  logic [pat_pkg::ANGLE_W-1:0]  ref_angle,
  input  pat_pkg::pat_cfg_t            cfg,
  output logic                         out_vld,
  output logic                         pass
);
  import pat_pkg::*;

  logic [ENERGY_W-1:0] hi_r, lo_r;
  logic [ANGLE_W-1:0]  dist_r;
  logic                v1_r, v2_r, pass_r;
  logic [ENERGY_W-1:0] bal;
  logic [ANGLE_W-1:0]  acop;
  logic                pass_nxt;

  // Stage one: order the energies and take the raw angle distance.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else begin
      v1_r <= in_vld;
    end
    if (cand_energy >= ref_energy) begin
      hi_r <= cand_energy;
      lo_r <= ref_energy;
    end else begin
      hi_r <= ref_energy;
      lo_r <= cand_energy;
    end
    dist_r <= (cand_angle >= ref_angle) ? cand_angle - ref_angle : ref_angle - cand_angle;
  end

  // Stage two: folding past half a turn and taking the complement both reduce to
  // the distance from half a turn.
  always_comb begin
    acop     = (dist_r > HALF_TURN) ? dist_r - HALF_TURN : HALF_TURN - dist_r;
    bal      = hi_r - lo_r;
    pass_nxt = (hi_r >= cfg.lead_energy_cut) && (lo_r >= cfg.sub_energy_cut)
            && (acop >= cfg.acop_min) && (acop <= cfg.acop_max)
            && (bal >= cfg.balance_min) && (bal <= cfg.balance_max);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else begin
      v2_r <= v1_r;
    end
    pass_r <= pass_nxt;
  end

  assign out_vld = v2_r;
  assign pass    = pass_r;

endmodule

### hw/rtl/pair_acoplanarity_trigger.sv
// Pair acoplanarity trigger: an item that is paired with n >= 1 stored candidates is tested
// against all n of them before the next item can be taken; an item that is not paired goes
// straight to the store step.
// The scan is set by the single read port of the candidate RAM, one entry a cycle.
// An item with last also passes the report step, held there while the previous result still waits.
// Reset (rst_n low, synchronous) clears the event counters, the FSM, the flags and the
// config to defaults; the data registers and the RAM keep their contents (no clearing pass).
module pair_acoplanarity_trigger #(
  parameter int MAX_CANDIDATES = 64
) (
  input  logic                clk,
  input  logic                rst_n,
  pat_in_if.sink              in_ch,
  pat_out_if.source           out_ch,
  input  logic                cfg_we,
  input  pat_pkg::cfg_idx_t   cfg_index,
  input  pat_pkg::cfg_data_t  cfg_data
);
  import pat_pkg::*;
  `include "assert_macros.svh"

  localparam int AW     = (MAX_CANDIDATES > 1) ? $clog2(MAX_CANDIDATES) : 1;
  localparam int CNT_W  = $clog2(MAX_CANDIDATES + 1);
  localparam int WORD_W = ENERGY_W + ANGLE_W;
  localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_CANDIDATES);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FIN,
    ST_EMIT
  } state_t;

  state_t              state_r;
  pat_cfg_t            cfg_r;
  logic [ENERGY_W-1:0] cand_energy_r;
  logic [ANGLE_W-1:0]  cand_angle_r;
  logic                last_r, store_r;
  logic [CNT_W-1:0]    count_r, idx_r, res_cnt_r, res_cnt_nxt;
  logic [PAIRS_W-1:0]  pairs_r;
  logic                dropped_r;
  logic                rd_vld_r;
  logic                out_valid_r, accept_r, overflow_r;
  logic [PAIRS_W-1:0]  pair_count_r;

  logic                in_fire, has_room, rd_en, ram_we, emit_load;
  logic [WORD_W-1:0]   rdata;
  logic                pass_vld, pass;

  assign in_fire     = in_ch.valid && in_ch.ready;
  assign has_room    = count_r < MAX_CNT;
  assign rd_en       = (state_r == ST_SCAN) && (idx_r < count_r);
  assign ram_we      = (state_r == ST_FIN) && store_r;
  assign res_cnt_nxt = res_cnt_r + CNT_W'(1);
  assign emit_load   = (state_r == ST_EMIT) && (!out_valid_r || out_ch.ready);

  // Configuration registers; an index past the list is ignored.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.lead_energy_cut <= '0;
      cfg_r.sub_energy_cut  <= '0;
      cfg_r.acop_min        <= '0;
      cfg_r.acop_max        <= HALF_TURN;
      cfg_r.balance_min     <= '0;
      cfg_r.balance_max     <= '1;
      cfg_r.pair_threshold  <= PAIRS_W'(1);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_LEAD_CUT:  cfg_r.lead_energy_cut <= cfg_data[ENERGY_W-1:0];
        REG_SUB_CUT:   cfg_r.sub_energy_cut  <= cfg_data[ENERGY_W-1:0];
        REG_ACOP_MIN:  cfg_r.acop_min        <= cfg_data[ANGLE_W-1:0];
        REG_ACOP_MAX:  cfg_r.acop_max        <= cfg_data[ANGLE_W-1:0];
        REG_BAL_MIN:   cfg_r.balance_min     <= cfg_data[ENERGY_W-1:0];
        REG_BAL_MAX:   cfg_r.balance_max     <= cfg_data[ENERGY_W-1:0];
        REG_THRESHOLD: cfg_r.pair_threshold  <= cfg_data[PAIRS_W-1:0];
        default: ;
      endcase
    end
  end

  // Candidate store: energy in the upper bits, angle in the lower bits.
  pat_ram #(
    .WIDTH(WORD_W),
    .DEPTH(MAX_CANDIDATES)
  ) u_store (
    .clk  (clk),
    .we   (ram_we),
    .waddr(count_r[AW-1:0]),
    .wdata({cand_energy_r, cand_angle_r}),
    .re   (rd_en),
    .raddr(idx_r[AW-1:0]),
    .rdata(rdata)
  );

  pat_pair_check u_check (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_vld     (rd_vld_r),
    .cand_energy(cand_energy_r),
    .cand_angle (cand_angle_r),
    .ref_energy (rdata[WORD_W-1:ANGLE_W]),
    .ref_angle  (rdata[ANGLE_W-1:0]),
    .cfg        (cfg_r),
    .out_vld    (pass_vld),
    .pass       (pass)
  );

  // Event sequencer: take an item, scan the stored entries when paired, store it, and report on last.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      idx_r       <= '0;
      res_cnt_r   <= '0;
      pairs_r     <= '0;
      dropped_r   <= 1'b0;
      rd_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
      last_r      <= 1'b0;
      store_r     <= 1'b0;
    end else begin
      rd_vld_r <= rd_en;
      if (emit_load) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        ST_IDLE: begin
          if (in_fire) begin
            cand_energy_r <= in_ch.energy;
            cand_angle_r  <= in_ch.angle;
            last_r        <= in_ch.last;
            store_r       <= in_ch.candidate_valid && has_room;
            idx_r         <= '0;
            res_cnt_r     <= '0;
            if (in_ch.candidate_valid && !has_room) begin
              dropped_r <= 1'b1;
            end
            if (in_ch.candidate_valid && has_room && (count_r != '0)) begin
              state_r <= ST_SCAN;
            end else begin
              state_r <= ST_FIN;
            end
          end
        end
        ST_SCAN: begin
          if (rd_en) begin
            idx_r <= idx_r + CNT_W'(1);
          end
          if (pass_vld) begin
            res_cnt_r <= res_cnt_nxt;
            if (pass && (pairs_r != PAIRS_MAX)) begin
              pairs_r <= pairs_r + PAIRS_W'(1);
            end
            if (res_cnt_nxt == count_r) begin
              state_r <= ST_FIN;
            end
          end
        end
        ST_FIN: begin
          if (store_r) begin
            count_r <= count_r + CNT_W'(1);
          end
          state_r <= last_r ? ST_EMIT : ST_IDLE;
        end
        ST_EMIT: begin
          if (emit_load) begin
            pair_count_r <= pairs_r;
            accept_r     <= pairs_r >= cfg_r.pair_threshold;
            overflow_r   <= dropped_r;
            count_r      <= '0;
            pairs_r      <= '0;
            dropped_r    <= 1'b0;
            state_r      <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign in_ch.ready       = (state_r == ST_IDLE);
  assign out_ch.valid      = out_valid_r;
  assign out_ch.pair_count = pair_count_r;
  assign out_ch.accept     = accept_r;
  assign out_ch.overflow   = overflow_r;

  // The store never holds more than its capacity.
  `PAT_ASSERT(a_count_cap, clk, rst_n, count_r <= MAX_CNT)
  // Writes never overlap a scan, so reads need no forwarding.
  `PAT_ASSERT(a_no_write_in_scan, clk, rst_n, ram_we |-> !rd_en && !rd_vld_r && !pass_vld)
  // Pair results only arrive while scanning, and never more than were issued.
  `PAT_ASSERT(a_result_in_scan, clk, rst_n, pass_vld |-> state_r == ST_SCAN && res_cnt_r < idx_r)
  // A scan reads only entries that were written in this event.
  `PAT_ASSERT(a_read_in_range, clk, rst_n, rd_en |-> idx_r < count_r && count_r != '0)
  // A result is loaded only from the report step.
  `PAT_ASSERT(a_emit_source, clk, rst_n, $rose(out_valid_r) |-> $past(state_r) == ST_EMIT)

endmodule
